@@ sv/sapq_pkg.sv @@
package sapq_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // fixed field widths of the channel words
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_COUNT_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  // broadcast to every cell for one accepted word
  typedef struct packed {
    logic ins;
    logic del;
    val_t value;
  } cmd_t;

endpackage

@@ sv/sapq_in_if.sv @@
interface sapq_in_if;
  import sapq_pkg::*;

  logic                          valid;
  logic                          ready;
  op_e                           op;
  logic signed [IN_VALUE_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

@@ sv/sapq_out_if.sv @@
interface sapq_out_if;
  import sapq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [OUT_VALUE_W-1:0] min_value;
  logic [OUT_COUNT_W-1:0]        count;
  logic                          empty_res;
  logic                          full_res;
  logic                          error;

  modport source (output valid, output min_value, output count, output empty_res,
                  output full_res, output error, input ready);
  modport sink   (input valid, input min_value, input count, input empty_res,
                  input full_res, input error, output ready);
endinterface

@@ sv/sapq_cell.sv @@
module sapq_cell (
  input  logic            clk_i,
  input  sapq_pkg::cmd_t  cmd_i,
  input  logic            occ_i,       // cell holds a live entry
  input  logic            left_le_i,   // all entries left of here are <= value
  input  sapq_pkg::val_t  left_val_i,
  input  sapq_pkg::val_t  right_val_i,
  output logic            le_o,
  output sapq_pkg::val_t  val_o,
  output sapq_pkg::val_t  nxt_o
);
  import sapq_pkg::*;

  val_t val_q, val_d;

  assign le_o = occ_i && (val_q <= cmd_i.value);

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (!left_le_i) begin
        val_d = left_val_i;        // shift up
      end else if (!le_o) begin
        val_d = cmd_i.value;       // insertion point
      end
    end else if (cmd_i.del) begin
      val_d = right_val_i;         // shift down
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign nxt_o = val_d;

endmodule

@@ sv/sorted_array_priority_queue.sv @@
// Sorted-array priority queue, minimum first, built as a row of CAPACITY cells.
// The result word for an accepted item is registered and offered in the next cycle.
// Throughput: one insert or delete per cycle; every cell compares and shifts
// in parallel, so the rate is set only by the output register handshake.
// Reset (rst_ni low, async) empties the queue and drops any pending result;
// cell contents are not cleared, since no cell at or above the count is read.
module sorted_array_priority_queue (
  input  logic clk_i,
  input  logic rst_ni,
  sapq_in_if.sink    in_i,
  sapq_out_if.source out_o
);
  import sapq_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             is_full, is_empty;
  logic             err;
  cmd_t             cmd;

  // per-cell signals
  logic             occ     [CAPACITY];
  logic             le      [CAPACITY];
  logic             left_le [CAPACITY];
  val_t             cell_val[CAPACITY];
  val_t             cell_nxt[CAPACITY];
  val_t             left_val[CAPACITY];
  val_t             right_val[CAPACITY];

  // output register
  logic                          ovalid_q;
  logic signed [OUT_VALUE_W-1:0] min_q, min_d;
  logic [OUT_COUNT_W-1:0]        count_q;
  logic                          empty_q, full_q, err_q;

  // Accept whenever the output register is free or being drained this cycle.
  assign in_i.ready = !ovalid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign is_full  = (cnt_q == CNT_W'(CAPACITY));
  assign is_empty = (cnt_q == '0);

  // Insert on full and delete on empty leave the queue alone and flag error.
  always_comb begin
    err = 1'b0;
    if (in_i.op == OP_INSERT) begin
      err = is_full;
    end else begin
      err = is_empty;
    end
  end

  assign cmd.ins   = accept && !err && (in_i.op == OP_INSERT);
  assign cmd.del   = accept && !err && (in_i.op == OP_DELETE);
  assign cmd.value = VALUE_WIDTH'(in_i.value);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd.del) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Cell row: each cell sees its left and right neighbors only. The left
  // "<=" flag runs as a chain; since the row is sorted it is a prefix mask.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < cnt_q);

    if (i == 0) begin : g_first
      assign left_le[i]  = 1'b1;
      assign left_val[i] = cell_val[i];
    end else begin : g_inner
      assign left_le[i]  = le[i-1];
      assign left_val[i] = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val[i] = cell_val[i];
    end else begin : g_mid
      assign right_val[i] = cell_val[i+1];
    end

    sapq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ[i]),
      .left_le_i   (left_le[i]),
      .left_val_i  (left_val[i]),
      .right_val_i (right_val[i]),
      .le_o        (le[i]),
      .val_o       (cell_val[i]),
      .nxt_o       (cell_nxt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Minimum is cell 0 after the update; zero when the queue ends up empty.
  assign min_d = (cnt_d != '0) ? OUT_VALUE_W'(cell_nxt[0]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (accept) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_q   <= min_d;
      count_q <= OUT_COUNT_W'(cnt_d);
      empty_q <= (cnt_d == '0);
      full_q  <= (cnt_d == CNT_W'(CAPACITY));
      err_q   <= err;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.min_value = min_q;
  assign out_o.count     = count_q;
  assign out_o.empty_res = empty_q;
  assign out_o.full_res  = full_q;
  assign out_o.error     = err_q;

  // ---------------------------------------------------------------- checks
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_err_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && err) |=> (out_o.valid && out_o.error && cnt_q == $past(cnt_q)))
    else $error("ignored item changed the queue or lost its error flag");

  a_del_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.del |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("delete did not drop one entry");

  for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_chk
    a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (CNT_W'(i + 1) < cnt_q) |-> (cell_val[i] <= cell_val[i+1]))
      else $error("cell row out of order");
  end

endmodule
